@@ sv/spa_pkg.sv @@
// spa_pkg: types and constants for the sparse polynomial arithmetic block.
// No dependencies.
package spa_pkg;

    typedef enum logic [2:0] {
        OP_LOAD_FIRST  = 3'd0,
        OP_LOAD_SECOND = 3'd1,
        OP_ADD         = 3'd2,
        OP_SUB         = 3'd3,
        OP_MUL         = 3'd4
    } op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_GEN_RD,
        ST_GEN_MUL,
        ST_GEN_WR,
        ST_SORT_RD,
        ST_SORT_CMP,
        ST_EMIT_RD,
        ST_EMIT_ACC,
        ST_EMIT_OUT,
        ST_EMPTY_OUT
    } state_t;

    localparam int EXP_W  = 15;
    localparam int COEF_W = 32;
    localparam int REXP_W = 16;
    // products reach 47 bits; up to 1024 of them can merge into one term
    localparam int SUM_W  = 64;

    typedef struct packed {
        logic load_first;
        logic load_second;
        logic gen_start;
        logic gen_step;
        logic gen_write;
        logic sort_start;
        logic sort_read;
        logic sort_cmp;
        logic emit_start;
        logic emit_read;
        logic emit_acc;
        logic emit_out;
        logic empty_out;
        logic clear_counts;
    } cmd_t;

    typedef struct packed {
        logic gen_done;
        logic work_empty;
        logic sort_done;
        logic emit_done;
        logic out_taken;
    } status_t;

endpackage

@@ sv/spa_if.sv @@
// spa_if: valid/ready channels for term words and result words.
// Depends on spa_pkg.
interface spa_in_if;
    logic                        valid;
    logic                        ready;
    logic [2:0]                  operation;
    logic [spa_pkg::EXP_W-1:0]   exponent;
    logic signed [spa_pkg::COEF_W-1:0] coefficient;
    modport source (output valid, operation, exponent, coefficient, input ready);
    modport sink (input valid, operation, exponent, coefficient, output ready);
endinterface

interface spa_out_if;
    logic                        valid;
    logic                        ready;
    logic [spa_pkg::REXP_W-1:0]  result_exponent;
    logic signed [spa_pkg::COEF_W-1:0] result_coefficient;
    logic                        saturated;
    logic                        empty_res;
    logic                        last_term;
    modport source (output valid, result_exponent, result_coefficient, saturated,
        empty_res, last_term, input ready);
    modport sink (input valid, result_exponent, result_coefficient, saturated,
        empty_res, last_term, output ready);
endinterface

@@ sv/spa_ctrl.sv @@
// spa_ctrl: command sequencer for load, generate, sort and merge phases.
// Depends on spa_pkg.
module spa_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [2:0]       in_op,
    output logic             in_ready,
    input  spa_pkg::status_t status,
    output spa_pkg::cmd_t    cmd
);
    import spa_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    wire is_cmd = in_op == OP_ADD || in_op == OP_SUB || in_op == OP_MUL;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (in_valid && is_cmd) state_next = ST_GEN_RD;
            ST_GEN_RD:    state_next = status.gen_done ?
                              (status.work_empty ? ST_EMPTY_OUT : ST_SORT_RD) : ST_GEN_MUL;
            ST_GEN_MUL:   state_next = ST_GEN_WR;
            ST_GEN_WR:    state_next = ST_GEN_RD;
            ST_SORT_RD:   state_next = status.sort_done ? ST_EMIT_RD : ST_SORT_CMP;
            ST_SORT_CMP:  state_next = ST_SORT_RD;
            ST_EMIT_RD:   state_next = ST_EMIT_ACC;
            ST_EMIT_ACC:  state_next = status.emit_done ? ST_EMIT_OUT : ST_EMIT_ACC;
            ST_EMIT_OUT:  if (status.out_taken) state_next = ST_EMIT_RD;
            ST_EMPTY_OUT: if (status.out_taken) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
        if (state_reg == ST_EMIT_OUT && status.out_taken && status.sort_done)
            state_next = ST_IDLE;
    end

    always_comb
    begin
        cmd = '0;
        in_ready = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load_first  = in_valid && in_op == OP_LOAD_FIRST;
                cmd.load_second = in_valid && in_op == OP_LOAD_SECOND;
                cmd.gen_start   = in_valid && is_cmd;
            end
            ST_GEN_RD:    cmd.gen_step = 1'b1;
            ST_GEN_MUL:   ;
            ST_GEN_WR:
            begin
                cmd.gen_write = 1'b1;
                cmd.clear_counts = 1'b0;
            end
            ST_SORT_RD:
            begin
                cmd.sort_read = 1'b1;
                cmd.clear_counts = status.sort_done;
                cmd.emit_start = status.sort_done;
            end
            ST_SORT_CMP:  cmd.sort_cmp = 1'b1;
            ST_EMIT_RD:   cmd.emit_read = 1'b1;
            ST_EMIT_ACC:  cmd.emit_acc = 1'b1;
            ST_EMIT_OUT:  cmd.emit_out = 1'b1;
            ST_EMPTY_OUT:
            begin
                cmd.empty_out = 1'b1;
                cmd.clear_counts = 1'b1;
            end
            default:      ;
        endcase
        if (state_reg == ST_GEN_RD && status.gen_done && !status.work_empty)
            cmd.sort_start = 1'b1;
    end
endmodule

@@ sv/spa_dp.sv @@
// spa_dp: operand stores, product unit, work memory with insertion sort and merge.
// Depends on spa_pkg.
module spa_dp #(
    parameter int MAX_TERMS = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  spa_pkg::cmd_t              cmd,
    output spa_pkg::status_t           status,
    input  logic [2:0]                 in_op,
    input  logic [spa_pkg::EXP_W-1:0]  in_exp,
    input  logic signed [spa_pkg::COEF_W-1:0] in_coef,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [spa_pkg::REXP_W-1:0] out_exp,
    output logic signed [spa_pkg::COEF_W-1:0] out_coef,
    output logic                       out_sat,
    output logic                       out_empty,
    output logic                       out_last
);
    import spa_pkg::*;

    localparam int TW = $clog2(MAX_TERMS + 1);
    localparam int IW = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int DEPTH = (MAX_TERMS > 2) ? MAX_TERMS * MAX_TERMS : 2 * MAX_TERMS;
    localparam int WD = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int NW = $clog2(DEPTH + 1);

    logic [EXP_W-1:0]         fe_mem [MAX_TERMS];
    logic signed [COEF_W-1:0] fc_mem [MAX_TERMS];
    logic [EXP_W-1:0]         se_mem [MAX_TERMS];
    logic signed [COEF_W-1:0] sc_mem [MAX_TERMS];
    logic [REXP_W-1:0]        we_mem [DEPTH];
    logic signed [SUM_W-1:0]  ws_mem [DEPTH];

    logic [TW-1:0] fcnt_reg, scnt_reg;
    logic [2:0]    op_reg;
    logic          phase_reg;
    logic [TW-1:0] i_reg, j_reg;
    logic [NW-1:0] n_reg;
    logic [EXP_W-1:0] ea_reg, eb_reg;
    logic signed [COEF_W-1:0] ca_reg, cb_reg;
    logic signed [SUM_W-1:0] term_reg;
    logic [REXP_W-1:0] texp_reg;

    // sort: key at position k, walking p downward
    logic [NW-1:0] k_reg, p_reg;
    logic [REXP_W-1:0] key_e_reg, rd_e_reg;
    logic signed [SUM_W-1:0] key_s_reg, rd_s_reg;
    logic          key_have_reg;

    // merge
    logic [NW-1:0] m_reg;
    logic [REXP_W-1:0] acc_e_reg;
    logic signed [SUM_W-1:0] acc_s_reg;
    logic          acc_first_reg;

    logic          ov_reg;
    logic [REXP_W-1:0] oe_reg;
    logic signed [COEF_W-1:0] oc_reg;
    logic          osat_reg, oempty_reg, olast_reg;

    wire gen_mul = op_reg == OP_MUL;
    logic gen_done;
    always_comb
    begin
        if (gen_mul)
            gen_done = fcnt_reg == '0 || scnt_reg == '0 || i_reg == fcnt_reg;
        else
            gen_done = phase_reg ? (j_reg == scnt_reg) : 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_first && fcnt_reg < TW'(MAX_TERMS))
        begin
            fe_mem[fcnt_reg[IW-1:0]] <= in_exp;
            fc_mem[fcnt_reg[IW-1:0]] <= in_coef;
        end
        if (cmd.load_second && scnt_reg < TW'(MAX_TERMS))
        begin
            se_mem[scnt_reg[IW-1:0]] <= in_exp;
            sc_mem[scnt_reg[IW-1:0]] <= in_coef;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fcnt_reg <= '0;
            scnt_reg <= '0;
        end
        else if (cmd.clear_counts)
        begin
            fcnt_reg <= '0;
            scnt_reg <= '0;
        end
        else
        begin
            if (cmd.load_first && fcnt_reg < TW'(MAX_TERMS))
                fcnt_reg <= fcnt_reg + 1'b1;
            if (cmd.load_second && scnt_reg < TW'(MAX_TERMS))
                scnt_reg <= scnt_reg + 1'b1;
        end
    end

    // operand fetch; add/sub phase 0 walks first, phase 1 second; mul reads both
    logic signed [2*COEF_W-1:0] prod;
    assign prod = ca_reg * cb_reg;

    // phase 0 with an empty first operand moves straight to phase 1
    always_ff @(posedge clk)
    begin
        if (cmd.gen_start)
        begin
            op_reg    <= in_op;
            i_reg     <= '0;
            j_reg     <= '0;
            n_reg     <= '0;
            phase_reg <= fcnt_reg == '0;
        end
        else if (cmd.gen_step && !gen_done)
        begin
            if (gen_mul)
            begin
                ea_reg <= fe_mem[i_reg[IW-1:0]];
                ca_reg <= fc_mem[i_reg[IW-1:0]];
                eb_reg <= se_mem[j_reg[IW-1:0]];
                cb_reg <= sc_mem[j_reg[IW-1:0]];
            end
            else if (!phase_reg)
            begin
                ea_reg <= fe_mem[i_reg[IW-1:0]];
                ca_reg <= fc_mem[i_reg[IW-1:0]];
            end
            else
            begin
                ea_reg <= se_mem[j_reg[IW-1:0]];
                ca_reg <= sc_mem[j_reg[IW-1:0]];
            end
        end
        if (!cmd.gen_start && !cmd.gen_write && !cmd.gen_step && gen_mul)
        begin
            texp_reg <= REXP_W'(ea_reg) + REXP_W'(eb_reg);
            term_reg <= SUM_W'(prod >>> 16);
        end
        else if (!cmd.gen_start && !cmd.gen_write && !cmd.gen_step)
        begin
            texp_reg <= REXP_W'(ea_reg);
            term_reg <= (phase_reg && op_reg == OP_SUB) ? -SUM_W'(ca_reg) : SUM_W'(ca_reg);
        end
        if (cmd.gen_write)
        begin
            n_reg <= n_reg + 1'b1;
            if (gen_mul)
            begin
                if (j_reg + 1'b1 == scnt_reg)
                begin
                    j_reg <= '0;
                    i_reg <= i_reg + 1'b1;
                end
                else
                    j_reg <= j_reg + 1'b1;
            end
            else if (!phase_reg)
            begin
                if (i_reg + 1'b1 == fcnt_reg)
                    phase_reg <= 1'b1;
                i_reg <= i_reg + 1'b1;
            end
            else
                j_reg <= j_reg + 1'b1;
        end
    end

    logic gen_done_eff;
    assign gen_done_eff = gen_done;

    // sort state machine inside datapath counters
    // sort_read: if no key held, read key at k; else read entry p-1
    // sort_cmp: compare, shift or place
    logic sort_done;
    assign sort_done = !key_have_reg && k_reg >= n_reg;

    // merge prefetches the next entry while it accumulates the current one
    logic [NW-1:0] rd_addr;
    always_comb
    begin
        if (cmd.emit_acc)
            rd_addr = m_reg + 1'b1;
        else if (cmd.emit_read)
            rd_addr = m_reg;
        else if (!key_have_reg)
            rd_addr = k_reg;
        else
            rd_addr = p_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.gen_write)
        begin
            we_mem[n_reg[WD-1:0]] <= texp_reg;
            ws_mem[n_reg[WD-1:0]] <= term_reg;
        end
        else if (cmd.sort_cmp && key_have_reg)
        begin
            if (p_reg != '0 && rd_e_reg > key_e_reg)
            begin
                we_mem[p_reg[WD-1:0]] <= rd_e_reg;
                ws_mem[p_reg[WD-1:0]] <= rd_s_reg;
            end
            else
            begin
                we_mem[p_reg[WD-1:0]] <= key_e_reg;
                ws_mem[p_reg[WD-1:0]] <= key_s_reg;
            end
        end
        rd_e_reg <= we_mem[rd_addr[WD-1:0]];
        rd_s_reg <= ws_mem[rd_addr[WD-1:0]];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            key_have_reg <= 1'b0;
        else if (cmd.sort_start)
            key_have_reg <= 1'b0;
        else if (cmd.sort_cmp)
        begin
            if (!key_have_reg)
                key_have_reg <= 1'b1;
            else if (!(p_reg != '0 && rd_e_reg > key_e_reg))
                key_have_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.sort_start)
            k_reg <= NW'(1);
        else if (cmd.sort_cmp)
        begin
            if (!key_have_reg)
            begin
                key_e_reg <= rd_e_reg;
                key_s_reg <= rd_s_reg;
                p_reg     <= k_reg;
            end
            else if (p_reg != '0 && rd_e_reg > key_e_reg)
                p_reg <= p_reg - 1'b1;
            else
                k_reg <= k_reg + 1'b1;
        end
    end

    // the key read itself needs p-1 compare only when p>0; p==0 places at once
    // merge: read m, accumulate run of equal exponents
    logic emit_done;
    assign emit_done = !acc_first_reg &&
        (m_reg >= n_reg || rd_e_reg != acc_e_reg);

    logic signed [SUM_W-1:0] sum_next;
    assign sum_next = acc_first_reg ? rd_s_reg : acc_s_reg + rd_s_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.emit_start)
            m_reg <= '0;
        if (cmd.emit_read)
            acc_first_reg <= 1'b1;
        if (cmd.emit_acc && !emit_done)
        begin
            acc_e_reg     <= rd_e_reg;
            acc_s_reg     <= sum_next;
            acc_first_reg <= 1'b0;
            m_reg         <= m_reg + 1'b1;
        end
    end

    localparam logic signed [SUM_W-1:0] QMAX = SUM_W'(64'sd2147483647);
    localparam logic signed [SUM_W-1:0] QMIN = -SUM_W'(64'sd2147483648);

    wire out_fire = ov_reg && out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ov_reg <= 1'b0;
        else if (out_fire)
            ov_reg <= 1'b0;
        else if ((cmd.emit_out || cmd.empty_out) && !ov_reg)
            ov_reg <= 1'b1;
    end

    logic loaded_reg;
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            loaded_reg <= 1'b0;
        else if (out_fire)
            loaded_reg <= 1'b0;
        else if ((cmd.emit_out || cmd.empty_out) && !ov_reg && !loaded_reg)
            loaded_reg <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit_out && !ov_reg)
        begin
            oe_reg     <= acc_e_reg;
            oempty_reg <= 1'b0;
            olast_reg  <= m_reg >= n_reg;
            if (acc_s_reg > QMAX)
            begin
                oc_reg <= 32'sh7fffffff; osat_reg <= 1'b1;
            end
            else if (acc_s_reg < QMIN)
            begin
                oc_reg <= 32'sh80000000; osat_reg <= 1'b1;
            end
            else
            begin
                oc_reg <= acc_s_reg[COEF_W-1:0]; osat_reg <= 1'b0;
            end
        end
        else if (cmd.empty_out && !ov_reg)
        begin
            oe_reg <= '0; oc_reg <= '0; osat_reg <= 1'b0;
            oempty_reg <= 1'b1; olast_reg <= 1'b1;
        end
    end

    assign out_valid = ov_reg;
    assign out_exp   = oe_reg;
    assign out_coef  = oc_reg;
    assign out_sat   = osat_reg;
    assign out_empty = oempty_reg;
    assign out_last  = olast_reg;

    assign status.gen_done   = gen_done_eff;
    assign status.work_empty = n_reg == '0;
    assign status.sort_done  = cmd.emit_out ? (m_reg >= n_reg) : sort_done;
    assign status.emit_done  = emit_done;
    assign status.out_taken  = out_fire && loaded_reg;
endmodule

@@ sv/sparse_polynomial_arith.sv @@
// sparse_polynomial_arith: top level, joins sequencer and datapath.
// Depends on spa_pkg, spa_if, spa_ctrl, spa_dp.
// Load words are accepted one per cycle while idle. An add, subtract or
// multiply command of n generated terms (n = first+second, or first*second)
// generates its terms with one product unit, sorts them by insertion sort
// in the work memory, then merges runs of equal exponents and emits one
// result word per run, subject to output stalls. A command with no terms
// returns its empty word. The input is not ready while a command runs.
module sparse_polynomial_arith #(
    parameter int MAX_TERMS = 8
) (
    input logic       clk,
    input logic       rst_n,
    spa_in_if.sink    in_ch,
    spa_out_if.source out_ch
);
    import spa_pkg::*;

    cmd_t    cmd;
    status_t status;

    spa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_ch.valid),
        .in_op    (in_ch.operation),
        .in_ready (in_ch.ready),
        .status   (status),
        .cmd      (cmd)
    );

    spa_dp #(.MAX_TERMS(MAX_TERMS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_op     (in_ch.operation),
        .in_exp    (in_ch.exponent),
        .in_coef   (in_ch.coefficient),
        .out_valid (out_ch.valid),
        .out_ready (out_ch.ready),
        .out_exp   (out_ch.result_exponent),
        .out_coef  (out_ch.result_coefficient),
        .out_sat   (out_ch.saturated),
        .out_empty (out_ch.empty_res),
        .out_last  (out_ch.last_term)
    );
endmodule
